// ===== design/kbs_pkg.sv =====
// ============================================================================
// kbs_pkg: shared types and constants for the kinematic bicycle step
// Holds the register indexes, clamp limits, CORDIC constants and the
// arctangent table used by the datapath modules.
// ============================================================================
package kbs_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 24;

    // Configuration register indexes.
    localparam logic [2:0] REG_WHEEL_BASE    = 3'd0;
    localparam logic [2:0] REG_STEP_TIME     = 3'd1;
    localparam logic [2:0] REG_START_X       = 3'd2;
    localparam logic [2:0] REG_START_Y       = 3'd3;
    localparam logic [2:0] REG_START_HEADING = 3'd4;
    localparam logic [2:0] REG_START_STEER   = 3'd5;

    localparam logic signed [15:0] SPEED_MAX = 16'sd7680;
    localparam logic signed [15:0] SPEED_MIN = -16'sd2560;
    localparam logic signed [15:0] RATE_LIM  = 16'sd8192;
    localparam logic signed [15:0] STEER_LIM = 16'sd12868;

    localparam logic signed [33:0] CORDIC_GAIN       = 34'sd652032874;
    localparam logic [16:0]        QUARTER_RAD_SCALE = 17'd102944;
    localparam logic [31:0]        INV_TWO_PI_Q32    = 32'd683565276;

    // Multiplier / divider operation codes.
    typedef enum logic [1:0] {
        MUL_OP = 2'd0,
        DIV_OP = 2'd1
    } t_arith_op;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOAD,
        ST_HEAD_ARG,
        ST_HEAD_CORDIC,
        ST_HEAD_ROT,
        ST_DX_M1,
        ST_DX_M2,
        ST_DY_M1,
        ST_DY_M2,
        ST_POS,
        ST_STEER_ARG,
        ST_STEER_CORDIC,
        ST_NUM_M1,
        ST_NUM_M2,
        ST_DEN,
        ST_DIV,
        ST_TURN,
        ST_OUT
    } t_state;

    function automatic logic signed [33:0] atan_q30(input logic [4:0] idx);
        logic signed [33:0] v;
        begin
            case (idx)
                5'd0:  v = 34'sh03243F6A8;
                5'd1:  v = 34'sh01DAC6705;
                5'd2:  v = 34'sh00FADBAFC;
                5'd3:  v = 34'sh007F56EA6;
                5'd4:  v = 34'sh003FEAB76;
                5'd5:  v = 34'sh001FFD55B;
                5'd6:  v = 34'sh000FFFAAA;
                5'd7:  v = 34'sh0007FFF55;
                5'd8:  v = 34'sh0003FFFEA;
                5'd9:  v = 34'sh0001FFFFD;
                5'd10: v = 34'sh0000FFFFF;
                5'd11: v = 34'sh00007FFFF;
                5'd12: v = 34'sh00003FFFF;
                5'd13: v = 34'sh00001FFFF;
                5'd14: v = 34'sh00000FFFF;
                5'd15: v = 34'sh000007FFF;
                5'd16: v = 34'sh000003FFF;
                5'd17: v = 34'sh000001FFF;
                5'd18: v = 34'sh000000FFF;
                5'd19: v = 34'sh0000007FF;
                5'd20: v = 34'sh0000003FF;
                5'd21: v = 34'sh0000001FF;
                5'd22: v = 34'sh0000000FF;
                5'd23: v = 34'sh00000007F;
                default: v = 34'sd0;
            endcase
            atan_q30 = v;
        end
    endfunction

endpackage

// ===== design/kinematic_bicycle_step.sv =====
// ============================================================================
// kinematic_bicycle_step: one forward-Euler step of a bicycle vehicle model
// Sequencer over a shared CORDIC and a bit-serial multiply/divide unit.
// ============================================================================
//  channel | signals                              | direction
//  input   | i_valid/o_ready, restart speed rate  | in
//  output  | o_valid/i_ready, pos x y heading str | out
//  config  | i_cfg_valid/o_cfg_ready, index data  | in
//
// Each result takes two CORDIC runs and nine passes of the bit-serial
// multiply/divide unit. One item is in flight at a time; the next input is
// taken in the cycle after the result is registered, and a result that is
// not taken stalls the next one before the output register. Reset is
// synchronous and restores the defaults.
module kinematic_bicycle_step #(
    parameter int CORDIC_STEPS = kbs_pkg::CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_restart,
    input  logic signed [15:0] i_speed,
    input  logic signed [15:0] i_steer_rate,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_pos_x_out,
    output logic signed [31:0] o_pos_y_out,
    output logic [15:0]        o_heading_out,
    output logic signed [15:0] o_steer_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    kbs_pkg::t_state r_state, n_state;

    logic [15:0]        r_wheel_base, r_step_time, r_start_heading;
    logic signed [31:0] r_start_x, r_start_y;
    logic signed [14:0] r_start_steer;

    logic signed [31:0] r_pos_x, r_pos_y;
    logic [15:0]        r_heading;
    logic signed [15:0] r_steer;
    logic               r_restart;
    logic signed [15:0] r_speed, r_rate;
    logic [1:0]         r_quad;
    logic signed [33:0] r_hc, r_hs, r_sc;
    logic signed [63:0] r_tmp;
    logic               r_neg;
    logic [63:0]        r_den;
    logic               r_out_valid;
    logic signed [31:0] r_ox, r_oy;
    logic [15:0]        r_oh;
    logic signed [15:0] r_os;

    // CORDIC hookup
    logic               c_start, c_done;
    logic signed [33:0] c_angle, c_cos, c_sin;
    // arith hookup
    logic               a_start, a_done;
    kbs_pkg::t_arith_op a_op;
    logic [63:0]        a_a, a_b, a_res;

    kbs_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(c_start), .i_angle(c_angle),
        .o_done(c_done), .o_cos(c_cos), .o_sin(c_sin)
    );

    kbs_arith u_arith (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(a_start), .i_op(a_op),
        .i_a(a_a), .i_b(a_b), .o_done(a_done), .o_res(a_res)
    );

    logic accept_in;
    logic out_load;
    assign o_ready     = (r_state == kbs_pkg::ST_IDLE);
    assign accept_in   = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;
    // The output register takes a new result once the previous one has left.
    assign out_load    = (r_state == kbs_pkg::ST_OUT) && (!r_out_valid || i_ready);

    // Combinational helpers for the datapath.
    logic signed [15:0] v_cl, rate_cl, st_cl;
    logic signed [33:0] rd_prod;
    logic signed [15:0] hres;
    logic signed [63:0] mag_sv;
    logic signed [63:0] signed_res;
    logic signed [33:0] dpos_x, dpos_y;
    logic signed [33:0] sum_x, sum_y;
    logic [63:0]        absv, absh;
    logic [63:0]        num_mag;

    always_comb begin
        v_cl    = (r_speed > kbs_pkg::SPEED_MAX) ? kbs_pkg::SPEED_MAX :
                  (r_speed < kbs_pkg::SPEED_MIN) ? kbs_pkg::SPEED_MIN : r_speed;
        rate_cl = (r_rate > kbs_pkg::RATE_LIM) ? kbs_pkg::RATE_LIM :
                  (r_rate < -kbs_pkg::RATE_LIM) ? -kbs_pkg::RATE_LIM : r_rate;
        st_cl   = (r_steer > kbs_pkg::STEER_LIM) ? kbs_pkg::STEER_LIM :
                  (r_steer < -kbs_pkg::STEER_LIM) ? -kbs_pkg::STEER_LIM : r_steer;
        rd_prod = 34'(rate_cl * $signed({1'b0, r_step_time})) + 34'sd32768;
        hres    = $signed(16'(r_heading - {r_quad, 14'd0}));
        absv    = v_cl[15] ? 64'(-64'(v_cl)) : 64'(v_cl);
        absh    = r_hc[33] ? 64'(-64'(r_hc)) : 64'(r_hc);
        num_mag = r_tmp[63] ? 64'(-r_tmp) : 64'(r_tmp);
        signed_res = r_neg ? -$signed(a_res) : $signed(a_res);
        mag_sv  = signed_res;
        dpos_x  = 34'((mag_sv + (64'sd1 <<< 37)) >>> 38);
        dpos_y  = dpos_x;
        sum_x   = 34'(r_pos_x) + dpos_x;
        sum_y   = 34'(r_pos_y) + dpos_y;
    end

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        sat32 = (v > 34'sd2147483647) ? 32'sh7FFFFFFF :
                (v < -34'sd2147483648) ? 32'sh80000000 : v[31:0];
    endfunction

    // Next state and unit starts.
    always_comb begin
        n_state = r_state;
        c_start = 1'b0;
        c_angle = '0;
        a_start = 1'b0;
        a_op    = kbs_pkg::MUL_OP;
        a_a     = '0;
        a_b     = '0;
        case (r_state)
            kbs_pkg::ST_IDLE:      if (accept_in) n_state = kbs_pkg::ST_LOAD;
            kbs_pkg::ST_LOAD:      n_state = kbs_pkg::ST_HEAD_ARG;
            kbs_pkg::ST_HEAD_ARG: begin
                c_start = 1'b1;
                c_angle = 34'(hres * $signed({1'b0, kbs_pkg::QUARTER_RAD_SCALE}));
                n_state = kbs_pkg::ST_HEAD_CORDIC;
            end
            kbs_pkg::ST_HEAD_CORDIC: if (c_done) n_state = kbs_pkg::ST_HEAD_ROT;
            kbs_pkg::ST_HEAD_ROT: begin
                // |v| * |hc|
                a_start = 1'b1;
                a_a     = absv;
                a_b     = absh;
                n_state = kbs_pkg::ST_DX_M1;
            end
            kbs_pkg::ST_DX_M1: if (a_done) begin
                a_start = 1'b1;
                a_a     = a_res;
                a_b     = 64'(r_step_time);
                n_state = kbs_pkg::ST_DX_M2;
            end
            kbs_pkg::ST_DX_M2: if (a_done) n_state = kbs_pkg::ST_DY_M1;
            kbs_pkg::ST_DY_M1: begin
                a_start = 1'b1;
                a_a     = absv;
                a_b     = r_hs[33] ? 64'(-64'(r_hs)) : 64'(r_hs);
                n_state = kbs_pkg::ST_DY_M2;
            end
            kbs_pkg::ST_DY_M2: if (a_done) begin
                a_start = 1'b1;
                a_a     = a_res;
                a_b     = 64'(r_step_time);
                n_state = kbs_pkg::ST_POS;
            end
            kbs_pkg::ST_POS: if (a_done) n_state = kbs_pkg::ST_STEER_ARG;
            kbs_pkg::ST_STEER_ARG: begin
                c_start = 1'b1;
                c_angle = 34'(r_steer) <<< 16;
                n_state = kbs_pkg::ST_STEER_CORDIC;
            end
            kbs_pkg::ST_STEER_CORDIC: if (c_done) begin
                a_start = 1'b1;
                a_a     = absv;
                a_b     = c_sin[33] ? 64'(-64'(c_sin)) : 64'(c_sin);
                n_state = kbs_pkg::ST_NUM_M1;
            end
            kbs_pkg::ST_NUM_M1: if (a_done) begin
                a_start = 1'b1;
                a_a     = a_res;
                a_b     = 64'(r_step_time);
                n_state = kbs_pkg::ST_NUM_M2;
            end
            kbs_pkg::ST_NUM_M2: if (a_done) begin
                a_start = 1'b1;
                a_a     = 64'(r_sc);
                a_b     = (r_wheel_base == 16'd0) ? 64'd1 : 64'(r_wheel_base);
                n_state = kbs_pkg::ST_DEN;
            end
            kbs_pkg::ST_DEN: if (a_done) begin
                // Numerator magnitude in Q19 plus half the divisor for rounding.
                a_start = 1'b1;
                a_op    = kbs_pkg::DIV_OP;
                a_a     = (num_mag << 19) + (a_res >> 1);
                a_b     = a_res;
                n_state = kbs_pkg::ST_DIV;
            end
            kbs_pkg::ST_DIV: if (a_done) begin
                a_start = 1'b1;
                a_a     = a_res;
                a_b     = 64'(kbs_pkg::INV_TWO_PI_Q32);
                n_state = kbs_pkg::ST_TURN;
            end
            kbs_pkg::ST_TURN: if (a_done) n_state = kbs_pkg::ST_OUT;
            kbs_pkg::ST_OUT:  if (out_load) n_state = kbs_pkg::ST_IDLE;
            default:          n_state = kbs_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kbs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    logic [63:0] num_full, turn_full;
    logic [15:0] turn16;
    assign num_full  = a_res + 64'd32768;
    assign turn_full = a_res + (64'd1 << 34);
    assign turn16    = turn_full[50:35];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheel_base    <= 16'd640;
            r_step_time     <= 16'd655;
            r_start_x       <= '0;
            r_start_y       <= '0;
            r_start_heading <= '0;
            r_start_steer   <= '0;
            r_pos_x         <= '0;
            r_pos_y         <= '0;
            r_heading       <= '0;
            r_steer         <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    kbs_pkg::REG_WHEEL_BASE:    r_wheel_base    <= i_cfg_data[15:0];
                    kbs_pkg::REG_STEP_TIME:     r_step_time     <= i_cfg_data[15:0];
                    kbs_pkg::REG_START_X:       r_start_x       <= i_cfg_data;
                    kbs_pkg::REG_START_Y:       r_start_y       <= i_cfg_data;
                    kbs_pkg::REG_START_HEADING: r_start_heading <= i_cfg_data[15:0];
                    kbs_pkg::REG_START_STEER:   r_start_steer   <= i_cfg_data[14:0];
                    default: ;
                endcase
            end
            if (out_load)
                r_out_valid <= 1'b1;
            else if (o_valid && i_ready)
                r_out_valid <= 1'b0;
            case (r_state)
                kbs_pkg::ST_IDLE: if (accept_in) begin
                    r_restart <= i_restart;
                    r_speed   <= i_speed;
                    r_rate    <= i_steer_rate;
                end
                kbs_pkg::ST_LOAD: begin
                    if (r_restart) begin
                        r_pos_x   <= r_start_x;
                        r_pos_y   <= r_start_y;
                        r_heading <= r_start_heading;
                        r_steer   <= 16'(r_start_steer);
                        r_quad    <= 2'(({2'b0, r_start_heading} + 18'h2000) >> 14);
                    end else begin
                        r_quad    <= 2'(({2'b0, r_heading} + 18'h2000) >> 14);
                    end
                end
                kbs_pkg::ST_HEAD_ARG: begin
                    // Steering update uses the clamped stored angle.
                    r_steer <= st_cl + 16'(rd_prod >>> 16);
                end
                kbs_pkg::ST_HEAD_CORDIC: if (c_done) begin
                    case (r_quad)
                        2'd1:    begin r_hc <= -c_sin; r_hs <= c_cos;  end
                        2'd2:    begin r_hc <= -c_cos; r_hs <= -c_sin; end
                        2'd3:    begin r_hc <= c_sin;  r_hs <= -c_cos; end
                        default: begin r_hc <= c_cos;  r_hs <= c_sin;  end
                    endcase
                end
                kbs_pkg::ST_HEAD_ROT: r_neg <= v_cl[15] ^ r_hc[33];
                kbs_pkg::ST_DX_M2: if (a_done) begin
                    r_pos_x <= sat32(sum_x);
                    r_neg   <= v_cl[15] ^ r_hs[33];
                end
                kbs_pkg::ST_POS: if (a_done) r_pos_y <= sat32(sum_y);
                kbs_pkg::ST_STEER_CORDIC: if (c_done) begin
                    r_sc  <= (c_cos < 34'sd1) ? 34'sd1 : c_cos;
                    r_neg <= v_cl[15] ^ c_sin[33];
                end
                kbs_pkg::ST_NUM_M2: if (a_done) begin
                    // Rounded signed numerator.
                    if (r_neg)
                        r_tmp <= $signed((64'((-$signed(a_res) + 64'sd32768) >>> 16)));
                    else
                        r_tmp <= $signed(num_full >> 16);
                end
                kbs_pkg::ST_DEN: if (a_done) begin
                    r_neg <= r_tmp[63];
                end
                kbs_pkg::ST_TURN: if (a_done) begin
                    r_heading <= r_neg ? 16'(r_heading - turn16) : 16'(r_heading + turn16);
                end
                kbs_pkg::ST_OUT: if (out_load) begin
                    r_ox <= r_pos_x;
                    r_oy <= r_pos_y;
                    r_oh <= r_heading;
                    r_os <= r_steer;
                end
                default: ;
            endcase
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pos_x_out   = r_ox;
    assign o_pos_y_out   = r_oy;
    assign o_heading_out = r_oh;
    assign o_steer_out   = r_os;

    a_busy_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != kbs_pkg::ST_IDLE) |-> !o_ready)
        else $error("input taken while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_pos_x_out)))
        else $error("result dropped");
    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(c_start && a_start))
        else $error("two units started at once");
endmodule

// ===== design/kbs_cordic.sv =====
// ============================================================================
// kbs_cordic: iterative rotation-mode CORDIC
// One micro-rotation per cycle on a shared adder set; angle in Q2.30,
// cosine and sine out in Q1.30.
// ============================================================================
module kbs_cordic #(
    parameter int CORDIC_STEPS = kbs_pkg::CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [33:0] i_angle,
    output logic               o_done,
    output logic signed [33:0] o_cos,
    output logic signed [33:0] o_sin
);
    localparam int NSTEP = (CORDIC_STEPS > kbs_pkg::ATAN_ENTRIES)
                           ? kbs_pkg::ATAN_ENTRIES : CORDIC_STEPS;

    logic signed [33:0] r_x, r_y, r_z;
    logic [4:0]         r_i;
    logic               r_busy;
    logic               r_done;
    logic signed [33:0] xs, ys;

    // Arithmetic right shift is a floor shift.
    assign xs = r_x >>> r_i;
    assign ys = r_y >>> r_i;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x    <= kbs_pkg::CORDIC_GAIN;
                r_y    <= '0;
                r_z    <= i_angle;
                r_i    <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (!r_z[33]) begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - kbs_pkg::atan_q30(r_i);
                end else begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + kbs_pkg::atan_q30(r_i);
                end
                r_i <= r_i + 5'd1;
                if (r_i == 5'(NSTEP - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_x;
    assign o_sin  = r_y;
endmodule

// ===== design/kbs_arith.sv =====
// ============================================================================
// kbs_arith: bit-serial multiplier and restoring divider
// Multiplies two unsigned operands one bit per cycle by shift and add, or
// divides one quotient bit per cycle. Signs are handled by the caller.
// ============================================================================
module kbs_arith (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  kbs_pkg::t_arith_op i_op,
    input  logic [63:0]       i_a,
    input  logic [63:0]       i_b,
    output logic              o_done,
    output logic [63:0]       o_res
);
    logic [63:0] r_a, r_b, r_acc;
    logic [6:0]  r_cnt;
    logic        r_busy, r_done;
    kbs_pkg::t_arith_op r_op;
    logic [64:0] rem_sh;

    assign rem_sh = {r_acc, r_a[63]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_b    <= i_b;
                r_acc  <= '0;
                r_op   <= i_op;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                case (r_op)
                    kbs_pkg::MUL_OP: begin
                        // Multiplier bits come from r_b, LSB first.
                        if (r_b[0]) r_acc <= r_acc + r_a;
                        r_a <= r_a << 1;
                        r_b <= r_b >> 1;
                    end
                    kbs_pkg::DIV_OP: begin
                        // r_a shifts out dividend bits and collects quotient bits.
                        if (rem_sh >= {1'b0, r_b}) begin
                            r_acc <= 64'(rem_sh - {1'b0, r_b});
                            r_a   <= {r_a[62:0], 1'b1};
                        end else begin
                            r_acc <= rem_sh[63:0];
                            r_a   <= {r_a[62:0], 1'b0};
                        end
                    end
                    default: ;
                endcase
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = (r_op == kbs_pkg::DIV_OP) ? r_a : r_acc;
endmodule
